// ===== rtl/hcc_pkg.sv =====
// shared types, register codes and saturation helper for the contact-force block
// no dependencies
package hcc_pkg;

    localparam int ACC_W  = 48;
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [1:0] REG_OVERLAP = 2'd0;
    localparam logic [1:0] REG_SPRING  = 2'd1;
    localparam logic [1:0] REG_DAMPING = 2'd2;
    localparam logic [1:0] REG_GRAVITY = 2'd3;

    localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

    // one classified pair beat, handed from the front to the back
    typedef struct packed {
        logic        has_prev;
        logic        contact;
        logic [30:0] x;
        logic        dv_neg;
        logic [32:0] dmag;
        logic [31:0] inv_lo;
        logic [31:0] inv_hi;
        logic        last;
    } pair_t;

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [49:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > 50'(ACC_HI))
            r = ACC_HI;
        else if (v < 50'(ACC_LO))
            r = ACC_LO;
        else
            r = v[ACC_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/hertz_chain_contact_forces.sv =====
// hertzian chain contact forces: a pair beat holds the back end for pop, 2-bit square root
// steps, the shared 35x32 multiplier sequence, force, combine and emit; a chain end adds an emit
// no-contact pairs skip root, spring, damping and force; a lone first particle only pops
// lower particle's result follows the upper beat's terms, later under stalls
// front queue holds 4 beats so input is taken while the back end works
// rst_n clears control, pointer and partial-sum state; no clearing pass; uses hcc_pkg, front, back
module hertz_chain_contact_forces
    import hcc_pkg::*;
#(
    parameter int MAX_PARTICLES = 4096
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // apb configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // particle input beats
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [31:0]             position,
    input  logic [31:0]             velocity,
    input  logic [31:0]             inverse_mass,
    input  logic                    last_particle,
    // acceleration result beats
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [11:0]             particle_index,
    output logic signed [ACC_W-1:0] acceleration,
    output logic                    chain_done
);

    logic [30:0] overlap_reg;
    logic [31:0] spring_reg;
    logic [31:0] damping_reg;
    logic [31:0] gravity_reg;

    logic  q_valid;
    logic  q_pop;
    pair_t q_data;

    assign pready = 1'b1;

    // register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_reg <= '0;
            spring_reg  <= '0;
            damping_reg <= '0;
            gravity_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_OVERLAP: overlap_reg <= pwdata[30:0];
                REG_SPRING:  spring_reg  <= pwdata;
                REG_DAMPING: damping_reg <= pwdata;
                REG_GRAVITY: gravity_reg <= pwdata;
                default:     ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_OVERLAP: prdata = {1'b0, overlap_reg};
            REG_SPRING:  prdata = spring_reg;
            REG_DAMPING: prdata = damping_reg;
            REG_GRAVITY: prdata = gravity_reg;
            default:     prdata = '0;
        endcase
    end

    // front: accept, pair distance and velocity difference, queue
    hcc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .position       (position),
        .velocity       (velocity),
        .inverse_mass   (inverse_mass),
        .last_particle  (last_particle),
        .overlap_length (overlap_reg),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop)
    );

    // back: force, acceleration terms, results
    hcc_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .q_pop            (q_pop),
        .spring_constant  (spring_reg),
        .damping_constant (damping_reg),
        .gravity_accel    (gravity_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .particle_index   (particle_index),
        .acceleration     (acceleration),
        .chain_done       (chain_done)
    );

endmodule

// ===== rtl/hcc_front.sv =====
// front end: accepts particle beats, forms the pair terms, queues them
// depends on hcc_pkg
module hcc_front
    import hcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] position,
    input  logic [31:0] velocity,
    input  logic [31:0] inverse_mass,
    input  logic        last_particle,
    input  logic [30:0] overlap_length,
    output logic        q_valid,
    output pair_t       q_data,
    input  logic        q_pop
);

    pair_t            mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     cnt_reg;
    logic [31:0]      prev_pos_reg, prev_vel_reg, prev_inv_reg;
    logic             have_prev_reg;

    logic signed [32:0] d, dv;
    logic [32:0]        absd;
    pair_t              entry;
    logic               push;

    assign in_ready = (cnt_reg != QDEPTH[QAW:0]);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        d    = $signed({prev_pos_reg[31], prev_pos_reg}) - $signed({position[31], position});
        absd = d[32] ? 33'(-d) : 33'(d);
        dv   = $signed({prev_vel_reg[31], prev_vel_reg}) - $signed({velocity[31], velocity});
        entry.has_prev = have_prev_reg;
        entry.contact  = absd < {2'b00, overlap_length};
        entry.x        = 31'({2'b00, overlap_length} - absd);
        entry.dv_neg   = dv[32];
        entry.dmag     = dv[32] ? 33'(-dv) : 33'(dv);
        entry.inv_lo   = prev_inv_reg;
        entry.inv_hi   = inverse_mass;
        entry.last     = last_particle;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
            prev_pos_reg        <= position;
            prev_vel_reg        <= velocity;
            prev_inv_reg        <= inverse_mass;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg    <= wr_ptr_reg + 1'b1;
                have_prev_reg <= !last_particle;
            end
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !q_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!push && q_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/hcc_back.sv =====
// back end: square root, shared multiplier sequence, accumulation and result register
// depends on hcc_pkg
module hcc_back
    import hcc_pkg::*;
#(
    parameter int MAX_PARTICLES = 4096
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  pair_t                   q_data,
    output logic                    q_pop,
    input  logic [31:0]             spring_constant,
    input  logic [31:0]             damping_constant,
    input  logic [31:0]             gravity_accel,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [11:0]             particle_index,
    output logic signed [ACC_W-1:0] acceleration,
    output logic                    chain_done
);

    localparam int CNT_W = (MAX_PARTICLES > 2) ? $clog2(MAX_PARTICLES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SQRT, S_MXS, S_MSPR, S_MDMP, S_FORCE,
        S_ML0, S_ML1, S_MCMB, S_EMIT1, S_EMIT2
    } state_t;

    state_t                  state_reg, state_next;
    pair_t                   cur_reg, cur_next;
    logic [55:0]             rad_reg, rad_next;
    logic [30:0]             rem_reg, rem_next;
    logic [27:0]             root_reg, root_next;
    logic [3:0]              iter_reg, iter_next;
    logic [66:0]             prod_reg, prod_next;
    logic [55:0]             lo_reg, lo_next;
    logic [46:0]             spring_reg, spring_next;
    logic [47:0]             fmag_reg, fmag_next;
    logic                    fneg_reg, fneg_next;
    logic                    upper_reg, upper_next;
    logic signed [ACC_W-1:0] pa_reg, pa_next;
    logic signed [ACC_W-1:0] term_reg, term_next;
    logic signed [ACC_W-1:0] partial_reg, partial_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    ov_reg, ov_next;
    logic [11:0]             oidx_reg, oidx_next;
    logic signed [ACC_W-1:0] oacc_reg, oacc_next;
    logic                    odone_reg, odone_next;

    logic [34:0]             mul_a;
    logic [31:0]             mul_b;
    logic                    out_free;
    logic [30:0]             r2;
    logic [30:0]             trial;
    logic [79:0]             total;
    logic [63:0]             amag;
    logic [46:0]             amag_sat;
    logic [50:0]             dshift;
    logic [46:0]             dmag_sat;
    logic signed [48:0]      fsum;
    logic signed [ACC_W-1:0] fval;
    logic signed [ACC_W-1:0] tval;
    logic [CNT_W+11:0]       idx_ext;

    assign out_valid      = ov_reg;
    assign particle_index = oidx_reg;
    assign acceleration   = oacc_reg;
    assign chain_done     = odone_reg;
    assign out_free       = !ov_reg || out_ready;
    assign idx_ext        = {12'b0, cnt_reg};

    function automatic logic signed [ACC_W-1:0] finish(
        input logic signed [ACC_W-1:0] a, input logic zero_idx, input logic [31:0] g);
        logic signed [ACC_W-1:0] r;
        if (zero_idx)
            r = '0;
        else
            r = sat48(50'(a) - 50'($signed(g)));
        return r;
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        iter_next    = iter_reg;
        prod_next    = prod_reg;
        lo_next      = lo_reg;
        spring_next  = spring_reg;
        fmag_next    = fmag_reg;
        fneg_next    = fneg_reg;
        upper_next   = upper_reg;
        pa_next      = pa_reg;
        term_next    = term_reg;
        partial_next = partial_reg;
        cnt_next     = cnt_reg;
        ov_next      = ov_reg && !out_ready;
        oidx_next    = oidx_reg;
        oacc_next    = oacc_reg;
        odone_next   = odone_reg;
        q_pop        = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        r2           = '0;
        trial        = '0;

        // accel term combine: (|f| * inv_mass) >> 16, capped
        total    = {prod_reg[55:0], 24'b0} + {24'b0, lo_reg};
        amag     = total[79:16];
        amag_sat = (amag > 64'(ACC_HI)) ? ACC_HI[46:0] : amag[46:0];
        tval     = fneg_reg ? -$signed({1'b0, amag_sat}) : $signed({1'b0, amag_sat});

        // damping term and pair force
        dshift   = prod_reg[66:16];
        dmag_sat = (dshift > 51'(ACC_HI)) ? ACC_HI[46:0] : dshift[46:0];
        fsum     = cur_reg.dv_neg ? 49'({2'b0, spring_reg}) - 49'({2'b0, dmag_sat})
                                  : 49'({2'b0, spring_reg}) + 49'({2'b0, dmag_sat});
        fval     = sat48(50'(fsum));

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    upper_next = 1'b0;
                    if (!q_data.has_prev)
                        state_next = q_data.last ? S_EMIT2 : S_IDLE;
                    else if (q_data.contact)
                    begin
                        rad_next   = {1'b0, q_data.x, 24'b0};
                        rem_next   = '0;
                        root_next  = '0;
                        iter_next  = '0;
                        state_next = S_SQRT;
                    end
                    else
                    begin
                        fmag_next  = '0;
                        fneg_next  = 1'b0;
                        state_next = S_ML0;
                    end
                end
            end
            S_SQRT:
            begin
                // two root bits per cycle
                r2    = {rem_reg[28:0], rad_reg[55:54]};
                trial = {1'b0, root_reg, 2'b01};
                if (r2 >= trial)
                begin
                    r2        = r2 - trial;
                    root_next = {root_reg[26:0], 1'b1};
                end
                else
                    root_next = {root_reg[26:0], 1'b0};
                r2    = {r2[28:0], rad_reg[53:52]};
                trial = {1'b0, root_next, 2'b01};
                if (r2 >= trial)
                begin
                    r2        = r2 - trial;
                    root_next = {root_next[26:0], 1'b1};
                end
                else
                    root_next = {root_next[26:0], 1'b0};
                rem_next = r2;
                rad_next = {rad_reg[51:0], 4'b0};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 4'd13)
                    state_next = S_MXS;
            end
            S_MXS:
            begin
                mul_a      = {4'b0, cur_reg.x};
                mul_b      = {4'b0, root_reg};
                prod_next  = 67'(mul_a * mul_b);
                state_next = S_MSPR;
            end
            S_MSPR:
            begin
                mul_a      = prod_reg[58:24];
                mul_b      = spring_constant;
                prod_next  = 67'(mul_a * mul_b);
                state_next = S_MDMP;
            end
            S_MDMP:
            begin
                spring_next = (prod_reg[66:8] > 59'(ACC_HI)) ? ACC_HI[46:0] : prod_reg[54:8];
                mul_a       = {2'b0, cur_reg.dmag};
                mul_b       = damping_constant;
                prod_next   = 67'(mul_a * mul_b);
                state_next  = S_FORCE;
            end
            S_FORCE:
            begin
                fneg_next  = fval[ACC_W-1];
                fmag_next  = fval[ACC_W-1] ? 48'(-fval) : 48'(fval);
                state_next = S_ML0;
            end
            S_ML0:
            begin
                mul_a      = {11'b0, fmag_reg[23:0]};
                mul_b      = upper_reg ? cur_reg.inv_hi : cur_reg.inv_lo;
                prod_next  = 67'(mul_a * mul_b);
                state_next = S_ML1;
            end
            S_ML1:
            begin
                lo_next    = prod_reg[55:0];
                mul_a      = {11'b0, fmag_reg[47:24]};
                mul_b      = upper_reg ? cur_reg.inv_hi : cur_reg.inv_lo;
                prod_next  = 67'(mul_a * mul_b);
                state_next = S_MCMB;
            end
            S_MCMB:
            begin
                if (!upper_reg)
                begin
                    pa_next    = sat48(50'(partial_reg) - 50'(tval));
                    upper_next = 1'b1;
                    state_next = S_ML0;
                end
                else
                begin
                    term_next  = tval;
                    state_next = S_EMIT1;
                end
            end
            S_EMIT1:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    oidx_next    = idx_ext[11:0];
                    oacc_next    = finish(pa_reg, cnt_reg == '0, gravity_accel);
                    odone_next   = 1'b0;
                    cnt_next     = (cnt_reg >= CNT_MAX) ? CNT_MAX : cnt_reg + 1'b1;
                    partial_next = term_reg;
                    state_next   = cur_reg.last ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    oidx_next    = idx_ext[11:0];
                    oacc_next    = finish(partial_reg, cnt_reg == '0, gravity_accel);
                    odone_next   = 1'b1;
                    cnt_next     = '0;
                    partial_next = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            partial_reg <= '0;
            cnt_reg     <= '0;
            ov_reg      <= 1'b0;
            upper_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            partial_reg <= partial_next;
            cnt_reg     <= cnt_next;
            ov_reg      <= ov_next;
            upper_reg   <= upper_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        iter_reg   <= iter_next;
        prod_reg   <= prod_next;
        lo_reg     <= lo_next;
        spring_reg <= spring_next;
        fmag_reg   <= fmag_next;
        fneg_reg   <= fneg_next;
        pa_reg     <= pa_next;
        term_reg   <= term_next;
        oidx_reg   <= oidx_next;
        oacc_reg   <= oacc_next;
        odone_reg  <= odone_next;
    end

endmodule
